// ----- rtl/slot_free_list_allocator_defines.svh -----
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SFLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sfla_pkg.sv -----
`timescale 1ns / 1ps

package sfla_pkg;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_FREED   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // control sequencer
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ----- rtl/sfla_ram.sv -----
`timescale 1ns / 1ps

module sfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read that holds between reads
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/slot_free_list_allocator.sv -----
// Slot allocator with a LIFO free list threaded through one slot memory.
// A new request is not accepted until the last one has executed. The accept cycle
// reads the slot memory entry (free-list head or slot to free); the execute state uses it.
// The request moves into the execute state, then its result into the output register when free.
// Reset: free list empty, used count zero; slot memory needs no clearing.
`timescale 1ns / 1ps
`include "slot_free_list_allocator_defines.svh"

module slot_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] slot_to_free
    input  logic       s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] slot_given
    output logic [1:0] m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (CNT_W > 8) ? CNT_W : 8;
    // entry layout: {is_free, end_of_list, next_link}
    localparam int EW    = IDX_W + 2;
    localparam int END_B = IDX_W;
    localparam int FREE_B = IDX_W + 1;

    state_t state_reg, state_next;

    logic             head_valid_reg, head_valid_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] used_reg, used_next;

    logic             req_kind_reg;
    logic [7:0]       req_slot_reg;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_slot_reg, m_slot_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic             s_accept;
    logic             exec_go;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [EW-1:0]    ram_rdata;

    logic [CW-1:0]    slot_cw;
    logic             free_reject;

    sfla_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        exec_go  = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);
    end

    assign s_accept = s_tvalid && s_tready;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // read the list head for allocate, the target entry for free
    assign ram_raddr = (s_tuser == KIND_FREE) ? IDX_W'(CW'(s_tdata)) : head_reg;

    assign slot_cw     = CW'(req_slot_reg);
    assign free_reject = (slot_cw >= CW'(used_reg)) || (slot_cw >= CW'(SLOTS))
                         || ram_rdata[FREE_B];

    // read-modify-write of the slot entry and list state
    always_comb begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = '0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_status_next   = m_status_reg;

        if (exec_go) begin
            m_valid_next = 1'b1;
            m_slot_next  = 8'd0;
            if (req_kind_reg == KIND_ALLOC) begin
                // allocated entry: not free, end of list
                ram_wdata = EW'(1) << END_B;
                priority if (head_valid_reg) begin
                    // pop the most recently freed slot
                    ram_we    = 1'b1;
                    ram_waddr = head_reg;
                    if (ram_rdata[END_B]) begin
                        head_valid_next = 1'b0;
                    end else begin
                        head_next = ram_rdata[IDX_W-1:0];
                    end
                    m_slot_next   = 8'(head_reg);
                    m_status_next = ST_ALLOC;
                end else if (used_reg < CNT_W'(SLOTS)) begin
                    // take a never-used slot
                    ram_we        = 1'b1;
                    ram_waddr     = used_reg[IDX_W-1:0];
                    used_next     = used_reg + CNT_W'(1);
                    m_slot_next   = 8'(used_reg[IDX_W-1:0]);
                    m_status_next = ST_ALLOC;
                end else begin
                    m_status_next = ST_FULL;
                end
            end else begin
                if (free_reject) begin
                    m_status_next = ST_IGNORED;
                end else begin
                    // push onto the free list
                    ram_we                 = 1'b1;
                    ram_waddr              = slot_cw[IDX_W-1:0];
                    ram_wdata[IDX_W-1:0]   = head_reg;
                    ram_wdata[END_B]       = !head_valid_reg;
                    ram_wdata[FREE_B]      = 1'b1;
                    head_next              = slot_cw[IDX_W-1:0];
                    head_valid_next        = 1'b1;
                    m_status_next          = ST_FREED;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_valid_reg <= 1'b0;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            used_reg       <= used_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        m_slot_reg   <= m_slot_next;
        m_status_reg <= m_status_next;
        if (s_accept) begin
            req_kind_reg <= s_tuser;
            req_slot_reg <= s_tdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_slot_reg;
    assign m_tuser  = m_status_reg;

    // checks
    `SFLA_ASSERT_NOW(a_used_bound, aclk, aresetn, 1'b1, used_reg <= CNT_W'(SLOTS))
    `SFLA_ASSERT_NOW(a_head_in_use, aclk, aresetn, head_valid_reg,
                     CNT_W'(head_reg) < used_reg)
    `SFLA_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_accept, state_reg == S_EXEC)
    `SFLA_ASSERT_NOW(a_full_only_when_exhausted, aclk, aresetn,
                     exec_go && req_kind_reg == KIND_ALLOC && m_status_next == ST_FULL,
                     !head_valid_reg && used_reg == CNT_W'(SLOTS))

endmodule
